// ===== sv/dq_pkg.sv =====
package dq_pkg;

    localparam int CMD_W     = 3;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int ENT_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - STAT_W - ENT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } dq_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // capture the incoming item
        logic exec;     // carry out the command
        logic capture;  // load read data into the output register
        logic step;     // advance the dump walk and read the next slot
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register is empty or leaving this cycle
        logic needs_read;  // command reads the store
        logic more;        // dump has entries left after the one being captured
    } dq_stat_t;

endpackage

// ===== sv/double_ended_queue_core.sv =====
// Bounded double-ended queue of signed 32-bit words kept in a ring RAM of DEPTH slots.
// Input stream (s_*): one command item per handshake: push front/back, pop front/back,
// or dump. Output stream (m_*): one result item per push/pop or unused code, one per held word for a
// dump (front to back), or a single empty-status item when a pop or dump finds nothing.
// m_tlast marks the final result of each command; entries is the count after it.
// Pushes, unused codes and empty pops or dumps load their result into the output register
// directly; pops and each dump item first pass through the RAM read, which is registered.
// Each further dump item is read only when the previous one leaves the output register.
// The controller handles one command at a time (take, execute, then read and capture as
// needed), and the RAM's single read port sets the dump pace.
// The result sits in an output register, so the next command is accepted while it waits;
// that command then holds until the register frees. If m_tready stays low the block
// stalls with no loss. Reset empties the queue (front slot 0, count 0); RAM contents
// are not cleared and need no clearing pass.
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,   // cmd[2:0], value[34:3], zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata,   // data[31:0], status[33:32],
                                                    // entries[38:34], zero pad
    output logic                         m_tlast
);

    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/dq_ram.sv =====
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/dq_ctrl.sv =====
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);

    import dq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_WALK = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait until the previous result has gone
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.needs_read ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = stat.more ? S_WALK : S_IDLE;
            end
            S_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/dq_dp.sv =====
module dq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    input  dq_pkg::dq_cmd_t              cmd,
    output dq_pkg::dq_stat_t             stat
);

    import dq_pkg::*;

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW1 = IW + 1;
    localparam logic [IW1-1:0] DEPTH_X = IW1'(DEPTH);

    // front + offset, modulo DEPTH (both operands below DEPTH)
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW1-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IW-1:0];
    endfunction

    dq_op_t              op_reg;
    logic signed [31:0]  value_reg;
    logic [IW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       walk_reg, walk_next;
    logic signed [31:0]  data_reg, data_next;
    dq_status_t          status_reg, status_next;
    logic [ENT_W-1:0]    entries_reg, entries_next;
    logic                last_reg, last_next;
    logic                valid_reg, valid_next;

    logic                full, empty, walk_last, out_free;
    logic                we, re;
    logic [IW-1:0]       waddr, raddr;
    logic [DATA_W-1:0]   rdata;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign walk_last = ((CW'(walk_reg) + CW'(1)) == count_reg);
    assign out_free  = !valid_reg || m_tready;

    always_comb
    begin
        stat.out_free   = out_free;
        stat.more       = (op_reg == CMD_DUMP) && !walk_last;
        stat.needs_read = 1'b0;
        case (op_reg)
            CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: stat.needs_read = !empty;
            default:                               stat.needs_read = 1'b0;
        endcase
    end

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        entries_next = entries_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        we           = 1'b0;
        waddr        = front_reg;
        re           = 1'b0;
        raddr        = front_reg;

        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end

        if (cmd.exec)
        begin
            // results that need no read are ready at once
            data_next   = '0;
            status_next = ST_OK;
            last_next   = 1'b1;
            case (op_reg)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
                        we         = 1'b1;
                        waddr      = front_next;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = wrap_add(front_reg, IW'(count_reg));
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = front_reg;
                        count_next = count_reg - CW'(1);
                        // popping the only word keeps the front slot
                        if (count_reg != CW'(1))
                        begin
                            front_next = wrap_add(front_reg, IW'(1));
                        end
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = wrap_add(front_reg, IW'(count_reg - CW'(1)));
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_DUMP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = front_reg;
                        walk_next = '0;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
            entries_next = ENT_W'(count_next);
            if (!stat.needs_read)
            begin
                valid_next = 1'b1;
            end
        end

        if (cmd.step)
        begin
            walk_next = walk_reg + IW'(1);
            re        = 1'b1;
            raddr     = wrap_add(front_reg, walk_next);
        end

        if (cmd.capture)
        begin
            data_next    = rdata;
            status_next  = ST_OK;
            entries_next = ENT_W'(count_reg);
            last_next    = !stat.more;
            valid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= dq_op_t'(s_tdata[CMD_W-1:0]);
            value_reg <= s_tdata[CMD_W +: DATA_W];
        end
        walk_reg    <= walk_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        entries_reg <= entries_next;
        last_reg    <= last_next;
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, entries_reg, status_reg, data_reg};

endmodule

// ===== dv/double_ended_queue_core_tb.sv =====
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES   = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int S_PAD_W      = S_TDATA_W - DATA_W - CMD_W;
    localparam int CMD_TOP      = (1 << CMD_W) - 1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        dq_status_t        status;
        logic [ENT_W-1:0]  entries;
        logic              last;
    } dq_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // deque shadow state
    logic [DATA_W-1:0] pred_ring [DEPTH];
    int                pred_front = 0;
    int                pred_held  = 0;

    dq_result_t due_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still due", $time, due_results.size());
            $display("double_ended_queue_core_tb: FAIL");
            $finish;
        end
    end

    function automatic void note_result(input logic [DATA_W-1:0] data,
                                        input dq_status_t status, input logic last);
        dq_result_t r;
        r.data    = data;
        r.status  = status;
        r.entries = pred_held[ENT_W-1:0];
        r.last    = last;
        due_results.push_back(r);
    endfunction

    function automatic void deque_apply(input logic [CMD_W-1:0] cmd,
                                        input logic [DATA_W-1:0] value);
        int i;
        logic [DATA_W-1:0] word;
        word = '0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (pred_held >= DEPTH)
                    note_result('0, ST_FULL, 1'b1);
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        pred_front = (pred_front + DEPTH - 1) % DEPTH;
                        pred_ring[pred_front] = value;
                    end
                    else
                        pred_ring[(pred_front + pred_held) % DEPTH] = value;
                    pred_held++;
                    note_result('0, ST_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (pred_held == 0)
                    note_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    if (cmd == CMD_POP_FRONT)
                    begin
                        word = pred_ring[pred_front];
                        pred_held--;
                        // front slot stays put when the last word leaves
                        if (pred_held != 0)
                            pred_front = (pred_front + 1) % DEPTH;
                    end
                    else
                    begin
                        word = pred_ring[(pred_front + pred_held - 1) % DEPTH];
                        pred_held--;
                    end
                    note_result(word, ST_OK, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                if (pred_held == 0)
                    note_result('0, ST_EMPTY, 1'b1);
                else
                    for (i = 0; i < pred_held; i++)
                        note_result(pred_ring[(pred_front + i) % DEPTH], ST_OK,
                                    i == pred_held - 1);
            end
            default:
                note_result('0, ST_OK, 1'b1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, value, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        deque_apply(cmd, value);
    endtask

    // sender goes quiet until every due result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        dq_result_t got;
        dq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data    = m_tdata[DATA_W-1:0];
            got.status  = dq_status_t'(m_tdata[DATA_W +: STAT_W]);
            got.entries = m_tdata[DATA_W+STAT_W +: ENT_W];
            got.last    = m_tlast;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got data=%h status=%0d %s%0d %s%0b",
                         $time, got.data, got.status, "entries=", got.entries,
                         "last=", got.last);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch: expected data=%h status=%0d entries=%0d last=%0b",
                             $time, want.data, want.status, want.entries, want.last);
                    $display("%0t:           actual data=%h status=%0d entries=%0d last=%0b",
                             $time, got.data, got.status, got.entries, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed();
        int c;
        send_item(CMD_POP_FRONT, rand_word());
        send_item(CMD_POP_BACK, rand_word());
        send_item(CMD_DUMP, rand_word());
        send_item(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(CMD_PUSH_BACK, 32'h8000_0000);
        send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(CMD_PUSH_BACK, 32'h0000_0000);
        send_item(CMD_DUMP, '0);
        for (c = CMD_DUMP + 1; c <= CMD_TOP; c++)
            send_item(c[CMD_W-1:0], rand_word());
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_POP_BACK, '0);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_POP_BACK, '0);
        // lone word popped from the front, then refill around it
        send_item(CMD_PUSH_BACK, 32'h5A5A_5A5A);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(CMD_PUSH_BACK, 32'h1234_5678);
        send_item(CMD_DUMP, '1);
        drain();
    endtask

    task automatic test_full_backpressure();
        int i;
        while (pred_held > 0)
            send_item(CMD_POP_BACK, rand_word());
        hold_req = HOLD_CYCLES;
        for (i = 0; i < DEPTH; i++)
            send_item(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word());
        send_item(CMD_PUSH_FRONT, rand_word());
        send_item(CMD_PUSH_BACK, rand_word());
        send_item(CMD_DUMP, rand_word());
        drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count, input int push_pct);
        int i;
        int r;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_item(CMD_W'($urandom_range(CMD_TOP, CMD_DUMP + 1)), rand_word());
            else if (r < 12)
                send_item(CMD_DUMP, rand_word());
            else if (r < 12 + push_pct)
                send_item($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word());
            else
                send_item($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, rand_word());
        end
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_backpressure();
        test_random_traffic(0, 0, 15, 60);
        test_random_traffic(80, 0, 15, 35);
        test_random_traffic(0, 80, 15, 60);
        test_random_traffic(28, 28, 15, 35);

        recv_stall_pct = 0;
        drain();
        repeat (END_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, due_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("double_ended_queue_core_tb: PASS");
        else
            $display("double_ended_queue_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/dq_dp.sv
sv/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
